FILE: rtl/soft_knee_rms_compressor_assert.svh
// Assertion macros shared by the compressor RTL.
`ifndef SOFT_KNEE_RMS_COMPRESSOR_ASSERT_SVH
`define SOFT_KNEE_RMS_COMPRESSOR_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define SKRC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define SKRC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/skrc_pkg.sv
// Shared types, constants and tables of the soft-knee compressor.
package skrc_pkg;

   localparam int MUL_W  = 33;
   localparam int PROD_W = 2 * MUL_W;

   // Register indexes on the configuration port
   localparam logic [2:0] REG_THRESHOLD = 3'd0;
   localparam logic [2:0] REG_SLOPE     = 3'd1;
   localparam logic [2:0] REG_KNEE      = 3'd2;
   localparam logic [2:0] REG_ATTACK    = 3'd3;
   localparam logic [2:0] REG_RELEASE   = 3'd4;
   localparam logic [2:0] REG_MAKEUP    = 3'd5;
   localparam logic [2:0] REG_CHANNELS  = 3'd6;

   // 10*log10(2) in Q16 and log2(10)/20 in Q24
   localparam logic [17:0] LOG_DB_CONST = 18'd197283;
   localparam logic [21:0] EXP_CONST    = 22'd2786635;

   typedef struct packed {
      logic signed [MUL_W-1:0] a;
      logic signed [MUL_W-1:0] b;
   } mul_req_type;

   typedef logic signed [PROD_W-1:0] mul_prod_type;

   // 2^(-2^-(idx+1)) in Q30
   function automatic logic [29:0] pow2_neg(input logic [3:0] idx);
      logic [29:0] v;
      case (idx)
         4'd0:    v = 30'd759250125;
         4'd1:    v = 30'd902905651;
         4'd2:    v = 30'd984625594;
         4'd3:    v = 30'd1028218693;
         4'd4:    v = 30'd1050733751;
         4'd5:    v = 30'd1062175491;
         4'd6:    v = 30'd1067942999;
         4'd7:    v = 30'd1070838486;
         4'd8:    v = 30'd1072289173;
         4'd9:    v = 30'd1073015252;
         4'd10:   v = 30'd1073378477;
         4'd11:   v = 30'd1073560135;
         4'd12:   v = 30'd1073650976;
         4'd13:   v = 30'd1073696399;
         4'd14:   v = 30'd1073719111;
         default: v = 30'd1073730468;
      endcase
      return v;
   endfunction

endpackage

FILE: rtl/skrc_mul.sv
// Shared signed multiplier with a registered product.
module skrc_mul import skrc_pkg::*; (
   input  logic         clock,
   input  mul_req_type  mul_req,
   output mul_prod_type mul_prod
);

   mul_prod_type prod_ff;

   // Register the product of the selected operands
   always_ff @(posedge clock) begin
      prod_ff <= $signed(mul_req.a) * $signed(mul_req.b);
   end

   assign mul_prod = prod_ff;

endmodule

FILE: rtl/soft_knee_rms_compressor.sv
// Top level of the soft-knee RMS compressor: sequencer and datapath.
//
// Input channel req_*: one stereo frame per transfer (req_valid/req_stall).
// Result channel rsp_*: one gained frame per input frame (rsp_valid/rsp_stall).
// Configuration: csr_write_enable, csr_index, csr_data write one register
// per cycle; write only while no frame is in flight.
// A frame is worked in steps on the one shared multiplier: 16 squarings
// of the mantissa for the log and up to 16 products for the exponent,
// besides a 30-step restoring divider on the soft-knee path and a
// normalizing shifter that moves 8 or 1 bits a cycle. req_stall stays
// high while a frame is being worked on and drops in the idle state
// after it, so a new frame is taken only once the last one is done.
// A finished result sits in the output register; if rsp_stall holds it
// there, the next frame is still taken and worked until its own result is
// ready, then waits until the output register is free.
// Reset (synchronous, active high) loads the default configuration, sets
// the envelope to -96 dB and empties the output register.
module soft_knee_rms_compressor import skrc_pkg::*; #(
   parameter int CHANNELS    = 2,
   parameter int SAMPLE_BITS = 24
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [SAMPLE_BITS-1:0] req_sample_zero,
   input  logic [SAMPLE_BITS-1:0] req_sample_one,
   input  logic                   req_block_end,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [SAMPLE_BITS-1:0] rsp_result_zero,
   output logic [SAMPLE_BITS-1:0] rsp_result_one,
   output logic                   rsp_result_end,
   input  logic                   csr_write_enable,
   input  logic [2:0]             csr_index,
   input  logic [16:0]            csr_data
);

`include "soft_knee_rms_compressor_assert.svh"

   localparam int SB        = SAMPLE_BITS;
   localparam int FRAC_BITS = SB - 1;
   localparam int MAX_CH    = (CHANNELS < 2) ? 1 : 2;
   localparam logic signed [37:0] MAXV = (38'sd1 <<< (SB - 1)) - 38'sd1;
   localparam logic signed [37:0] MINV = -MAXV - 38'sd1;

   // Sequencer codes
   localparam logic [4:0] ST_IDLE  = 5'd0;
   localparam logic [4:0] ST_SQ0   = 5'd1;
   localparam logic [4:0] ST_SQ1   = 5'd2;
   localparam logic [4:0] ST_SQ2   = 5'd3;
   localparam logic [4:0] ST_NORM  = 5'd4;
   localparam logic [4:0] ST_LOGM  = 5'd5;
   localparam logic [4:0] ST_LOGS  = 5'd6;
   localparam logic [4:0] ST_LDB   = 5'd7;
   localparam logic [4:0] ST_LDB2  = 5'd8;
   localparam logic [4:0] ST_ENV   = 5'd9;
   localparam logic [4:0] ST_ENV2  = 5'd10;
   localparam logic [4:0] ST_GAIN  = 5'd11;
   localparam logic [4:0] ST_HARD  = 5'd12;
   localparam logic [4:0] ST_KNEE1 = 5'd13;
   localparam logic [4:0] ST_KNEE2 = 5'd14;
   localparam logic [4:0] ST_DIV   = 5'd15;
   localparam logic [4:0] ST_KNEEQ = 5'd16;
   localparam logic [4:0] ST_EXP   = 5'd17;
   localparam logic [4:0] ST_EXP2  = 5'd18;
   localparam logic [4:0] ST_LINM  = 5'd19;
   localparam logic [4:0] ST_LINR  = 5'd20;
   localparam logic [4:0] ST_LSH   = 5'd21;
   localparam logic [4:0] ST_MK    = 5'd22;
   localparam logic [4:0] ST_MK2   = 5'd23;
   localparam logic [4:0] ST_OUT0  = 5'd24;
   localparam logic [4:0] ST_OUT1  = 5'd25;
   localparam logic [4:0] ST_OUT2  = 5'd26;
   localparam logic [4:0] ST_DONE  = 5'd27;

   // Control and configuration registers
   logic [4:0]         state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [14:0] thr_ff, thr_in;
   logic signed [16:0] slope_ff, slope_in;
   logic [12:0]        knee_ff, knee_in;
   logic [15:0]        attack_ff, attack_in;
   logic [15:0]        release_ff, release_in;
   logic [14:0]        makeup_ff, makeup_in;
   logic [1:0]         active_ff, active_in;
   logic signed [15:0] env_ff, env_in;

   // Datapath registers
   logic signed [SB-1:0] x0_ff, x0_in, x1_ff, x1_in;
   logic                 end_ff, end_in;
   logic                 two_ff, two_in;
   logic [63:0]          sum_ff, sum_in;
   logic [5:0]           sh_ff, sh_in;
   logic [30:0]          m_ff, m_in;
   logic [15:0]          frac_ff, frac_in;
   logic [4:0]           cnt_ff, cnt_in;
   logic signed [15:0]   lvl_ff, lvl_in;
   logic signed [15:0]   g_ff, g_in;
   logic                 neg_ff, neg_in;
   logic [29:0]          div_ff, div_in;
   logic [12:0]          rem_ff, rem_in;
   logic [5:0]           ip_ff, ip_in;
   logic [15:0]          fp_ff, fp_in;
   logic [30:0]          lin_ff, lin_in;
   logic [30:0]          gq_ff, gq_in;
   logic signed [SB-1:0] y0_ff, y0_in, y1_ff, y1_in;
   logic signed [SB-1:0] rz_ff, rz_in, ro_ff, ro_in;
   logic                 re_ff, re_in;

   mul_req_type  mul_req;
   mul_prod_type prod;

   // Helper values
   logic               in_xfer, out_free;
   logic [64:0]        pair_sum;
   logic [63:0]        mean_sq;
   logic [31:0]        sq_v;
   logic signed [7:0]  p_off;
   logic signed [23:0] l2;
   logic [23:0]        l2_mag;
   logic [47:0]        ldb_t;
   logic [23:0]        ldb_d;
   logic signed [16:0] env_d;
   logic [15:0]        coef;
   logic [33:0]        env_t;
   logic signed [17:0] env_r;
   logic signed [18:0] env_n;
   logic signed [17:0] diff;
   logic signed [18:0] twod, k_s, t_knee;
   logic [36:0]        hard_t;
   logic signed [20:0] hard_r;
   logic [47:0]        num, num_mag;
   logic [48:0]        knee_n;
   logic [13:0]        rem_w;
   logic               rem_ge;
   logic [16:0]        g_mag;
   logic [37:0]        exp_t;
   logic [61:0]        lin_t;
   logic [46:0]        mk_t;
   logic [63:0]        out_t;
   logic signed [37:0] y_w;
   logic [SB-1:0]      y_sat;

   skrc_mul u_mul (
      .clock    (clock),
      .mul_req  (mul_req),
      .mul_prod (prod)
   );

   assign in_xfer  = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign pair_sum = {1'b0, sum_ff} + {1'b0, prod[63:0]};
   assign mean_sq  = two_ff ? pair_sum[64:1] : sum_ff;
   assign sq_v     = prod[61:30];
   assign p_off    = $signed({2'b00, ~sh_ff}) - 8'sd1 * 8'(2 * FRAC_BITS);
   assign l2       = {p_off, frac_ff};
   assign l2_mag   = 24'd0 - l2;
   assign ldb_t    = prod[47:0] + 48'd8388608;
   assign ldb_d    = ldb_t[47:24];

   assign env_d = {env_ff[15], env_ff} - {lvl_ff[15], lvl_ff};
   assign coef  = (lvl_ff > env_ff) ? attack_ff : release_ff;
   assign env_t = prod[33:0] + 34'd32768;
   assign env_r = $signed(env_t[33:16]);
   assign env_n = {{3{lvl_ff[15]}}, lvl_ff} + {env_r[17], env_r};

   assign diff   = {{2{env_ff[15]}}, env_ff} - {{3{thr_ff[14]}}, thr_ff};
   assign twod   = {diff, 1'b0};
   assign k_s    = {6'b0, knee_ff};
   assign t_knee = twod + k_s;
   assign hard_t = prod[36:0] + 37'd32768;
   assign hard_r = $signed(hard_t[36:16]);

   assign num     = prod[47:0];
   assign num_mag = num[47] ? 48'd0 - num : num;
   assign knee_n  = {1'b0, num_mag} + {17'b0, knee_ff, 18'b0} - {48'b0, num[47]};
   assign rem_w   = {rem_ff, div_ff[29]};
   assign rem_ge  = rem_w >= {1'b0, knee_ff};

   assign g_mag = 17'd0 - {g_ff[15], g_ff};
   assign exp_t = prod[37:0] + 38'd32768;
   assign lin_t = prod[61:0] + 62'd536870912;
   assign mk_t  = prod[46:0] + 47'd16384;
   assign out_t = prod[63:0] + 64'd33554432;
   assign y_w   = $signed(out_t[63:26]);
   assign y_sat = (y_w > MAXV) ? SB'(MAXV) : ((y_w < MINV) ? SB'(MINV) : SB'(y_w));

   // Select the multiplier operands for the current step
   always_comb begin
      mul_req.a = '0;
      mul_req.b = '0;
      case (state_ff)
         ST_SQ0: begin
            mul_req.a = MUL_W'(x0_ff);
            mul_req.b = MUL_W'(x0_ff);
         end
         ST_SQ1: begin
            mul_req.a = MUL_W'(x1_ff);
            mul_req.b = MUL_W'(x1_ff);
         end
         ST_LOGM: begin
            mul_req.a = MUL_W'(m_ff);
            mul_req.b = MUL_W'(m_ff);
         end
         ST_LDB: begin
            mul_req.a = MUL_W'(l2_mag);
            mul_req.b = MUL_W'(LOG_DB_CONST);
         end
         ST_ENV: begin
            mul_req.a = MUL_W'(coef);
            mul_req.b = MUL_W'(env_d);
         end
         ST_GAIN: begin
            if (twod < k_s) begin
               mul_req.a = MUL_W'(t_knee[13:0]);
               mul_req.b = MUL_W'(t_knee[13:0]);
            end else begin
               mul_req.a = MUL_W'(slope_ff);
               mul_req.b = MUL_W'(diff);
            end
         end
         ST_KNEE1: begin
            mul_req.a = MUL_W'(slope_ff);
            mul_req.b = MUL_W'(prod[27:0]);
         end
         ST_EXP: begin
            mul_req.a = MUL_W'(g_mag);
            mul_req.b = MUL_W'(EXP_CONST);
         end
         ST_LINM: begin
            mul_req.a = MUL_W'(lin_ff);
            mul_req.b = MUL_W'(pow2_neg(cnt_ff[3:0]));
         end
         ST_MK: begin
            mul_req.a = MUL_W'(lin_ff);
            mul_req.b = MUL_W'(makeup_ff);
         end
         ST_OUT0: begin
            mul_req.a = MUL_W'(x0_ff);
            mul_req.b = MUL_W'(gq_ff);
         end
         ST_OUT1: begin
            mul_req.a = MUL_W'(x1_ff);
            mul_req.b = MUL_W'(gq_ff);
         end
         default: begin
            mul_req.a = '0;
            mul_req.b = '0;
         end
      endcase
   end

   // Sequencer and datapath next values
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      thr_in       = thr_ff;
      slope_in     = slope_ff;
      knee_in      = knee_ff;
      attack_in    = attack_ff;
      release_in   = release_ff;
      makeup_in    = makeup_ff;
      active_in    = active_ff;
      env_in       = env_ff;
      x0_in        = x0_ff;
      x1_in        = x1_ff;
      end_in       = end_ff;
      two_in       = two_ff;
      sum_in       = sum_ff;
      sh_in        = sh_ff;
      m_in         = m_ff;
      frac_in      = frac_ff;
      cnt_in       = cnt_ff;
      lvl_in       = lvl_ff;
      g_in         = g_ff;
      neg_in       = neg_ff;
      div_in       = div_ff;
      rem_in       = rem_ff;
      ip_in        = ip_ff;
      fp_in        = fp_ff;
      lin_in       = lin_ff;
      gq_in        = gq_ff;
      y0_in        = y0_ff;
      y1_in        = y1_ff;
      rz_in        = rz_ff;
      ro_in        = ro_ff;
      re_in        = re_ff;

      // Write a configuration register
      if (csr_write_enable) begin
         case (csr_index)
            REG_THRESHOLD: thr_in     = $signed(csr_data[14:0]);
            REG_SLOPE:     slope_in   = $signed(csr_data[16:0]);
            REG_KNEE:      knee_in    = csr_data[12:0];
            REG_ATTACK:    attack_in  = csr_data[15:0];
            REG_RELEASE:   release_in = csr_data[15:0];
            REG_MAKEUP:    makeup_in  = csr_data[14:0];
            REG_CHANNELS:  active_in  = csr_data[1:0];
            default: ;
         endcase
      end

      // Drop the result once it transfers
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (in_xfer) begin
               x0_in    = $signed(req_sample_zero);
               x1_in    = $signed(req_sample_one);
               end_in   = req_block_end;
               two_in   = (active_ff >= 2'd2) && (MAX_CH == 2);
               state_in = ST_SQ0;
            end
         end
         ST_SQ0: state_in = ST_SQ1;
         ST_SQ1: begin
            sum_in   = prod[63:0];
            state_in = ST_SQ2;
         end
         ST_SQ2: begin
            sum_in = mean_sq;
            sh_in  = '0;
            if (mean_sq == '0) begin
               lvl_in   = -16'sd32768;
               state_in = ST_ENV;
            end else begin
               state_in = ST_NORM;
            end
         end
         // Normalize so the leading one sits at the top bit
         ST_NORM: begin
            if (sum_ff[63:56] == '0) begin
               sum_in = {sum_ff[55:0], 8'b0};
               sh_in  = sh_ff + 6'd8;
            end else if (!sum_ff[63]) begin
               sum_in = {sum_ff[62:0], 1'b0};
               sh_in  = sh_ff + 6'd1;
            end else begin
               m_in     = sum_ff[63:33];
               frac_in  = '0;
               cnt_in   = '0;
               state_in = ST_LOGM;
            end
         end
         ST_LOGM: state_in = ST_LOGS;
         // Take one fraction bit of log2 per squaring
         ST_LOGS: begin
            if (sq_v[31]) begin
               m_in = sq_v[31:1];
               frac_in[4'd15 - cnt_ff[3:0]] = 1'b1;
            end else begin
               m_in = sq_v[30:0];
            end
            if (cnt_ff[3:0] == 4'd15) begin
               state_in = ST_LDB;
            end else begin
               cnt_in   = cnt_ff + 5'd1;
               state_in = ST_LOGM;
            end
         end
         ST_LDB: begin
            if (!l2[23]) begin
               lvl_in   = '0;
               state_in = ST_ENV;
            end else begin
               state_in = ST_LDB2;
            end
         end
         ST_LDB2: begin
            lvl_in   = (ldb_d >= 24'd32768) ? -16'sd32768 : $signed(16'd0 - ldb_d[15:0]);
            state_in = ST_ENV;
         end
         ST_ENV: state_in = ST_ENV2;
         // Advance the envelope
         ST_ENV2: begin
            if (env_n > 19'sd32767) begin
               env_in = 16'sd32767;
            end else if (env_n < -19'sd32768) begin
               env_in = -16'sd32768;
            end else begin
               env_in = env_n[15:0];
            end
            state_in = ST_GAIN;
         end
         // Pick the curve segment
         ST_GAIN: begin
            if (twod < -k_s) begin
               g_in     = '0;
               state_in = ST_EXP;
            end else if (twod < k_s) begin
               state_in = ST_KNEE1;
            end else begin
               state_in = ST_HARD;
            end
         end
         ST_HARD: begin
            if (hard_r > 21'sd0) begin
               g_in = '0;
            end else if (hard_r < -21'sd32768) begin
               g_in = -16'sd32768;
            end else begin
               g_in = hard_r[15:0];
            end
            state_in = ST_EXP;
         end
         ST_KNEE1: state_in = ST_KNEE2;
         ST_KNEE2: begin
            neg_in   = num[47];
            div_in   = knee_n[48:19];
            rem_in   = '0;
            cnt_in   = '0;
            state_in = ST_DIV;
         end
         // Restoring division by the knee width, one bit a cycle
         ST_DIV: begin
            rem_in = rem_ge ? 13'(rem_w - {1'b0, knee_ff}) : rem_w[12:0];
            div_in = {div_ff[28:0], rem_ge};
            if (cnt_ff == 5'd29) begin
               state_in = ST_KNEEQ;
            end else begin
               cnt_in = cnt_ff + 5'd1;
            end
         end
         ST_KNEEQ: begin
            if (neg_ff && div_ff != '0) begin
               g_in = (div_ff >= 30'd32768) ? -16'sd32768 : $signed(16'd0 - div_ff[15:0]);
            end else begin
               g_in = '0;
            end
            state_in = ST_EXP;
         end
         ST_EXP: state_in = ST_EXP2;
         ST_EXP2: begin
            ip_in    = exp_t[37:32];
            fp_in    = exp_t[31:16];
            lin_in   = 31'd1 << 30;
            cnt_in   = '0;
            state_in = ST_LINM;
         end
         // Multiply in one table factor per set fraction bit
         ST_LINM: begin
            if (fp_ff[4'd15 - cnt_ff[3:0]]) begin
               state_in = ST_LINR;
            end else if (cnt_ff[3:0] == 4'd15) begin
               state_in = ST_LSH;
            end else begin
               cnt_in = cnt_ff + 5'd1;
            end
         end
         ST_LINR: begin
            lin_in = lin_t[60:30];
            if (cnt_ff[3:0] == 4'd15) begin
               state_in = ST_LSH;
            end else begin
               cnt_in   = cnt_ff + 5'd1;
               state_in = ST_LINM;
            end
         end
         ST_LSH: begin
            lin_in   = (ip_ff >= 6'd31) ? '0 : (lin_ff >> ip_ff[4:0]);
            state_in = ST_MK;
         end
         ST_MK: state_in = ST_MK2;
         ST_MK2: begin
            gq_in    = mk_t[45:15];
            state_in = ST_OUT0;
         end
         ST_OUT0: state_in = ST_OUT1;
         ST_OUT1: begin
            y0_in    = y_sat;
            state_in = ST_OUT2;
         end
         ST_OUT2: begin
            y1_in    = two_ff ? y_sat : '0;
            state_in = ST_DONE;
         end
         // Hold until the output register is free
         ST_DONE: begin
            if (out_free) begin
               rz_in        = y0_ff;
               ro_in        = y1_ff;
               re_in        = end_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         thr_ff       <= -15'sd4608;
         slope_ff     <= -17'sd49152;
         knee_ff      <= 13'd1536;
         attack_ff    <= 16'd65400;
         release_ff   <= 16'd65522;
         makeup_ff    <= 15'd2048;
         active_ff    <= 2'd2;
         env_ff       <= -16'sd24576;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         thr_ff       <= thr_in;
         slope_ff     <= slope_in;
         knee_ff      <= knee_in;
         attack_ff    <= attack_in;
         release_ff   <= release_in;
         makeup_ff    <= makeup_in;
         active_ff    <= active_in;
         env_ff       <= env_in;
      end
   end

   // Datapath payload
   always_ff @(posedge clock) begin
      x0_ff   <= x0_in;
      x1_ff   <= x1_in;
      end_ff  <= end_in;
      two_ff  <= two_in;
      sum_ff  <= sum_in;
      sh_ff   <= sh_in;
      m_ff    <= m_in;
      frac_ff <= frac_in;
      cnt_ff  <= cnt_in;
      lvl_ff  <= lvl_in;
      g_ff    <= g_in;
      neg_ff  <= neg_in;
      div_ff  <= div_in;
      rem_ff  <= rem_in;
      ip_ff   <= ip_in;
      fp_ff   <= fp_in;
      lin_ff  <= lin_in;
      gq_ff   <= gq_in;
      y0_ff   <= y0_in;
      y1_ff   <= y1_in;
      rz_ff   <= rz_in;
      ro_ff   <= ro_in;
      re_ff   <= re_in;
   end

   assign req_stall       = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_zero = rz_ff;
   assign rsp_result_one  = ro_ff;
   assign rsp_result_end  = re_ff;

   // Checks on sequencing
   `SKRC_ASSERT_NEXT(a_accept_starts, clock, reset, in_xfer, state_ff == ST_SQ0, "accept did not start")
   `SKRC_ASSERT_NEXT(a_env_hold, clock, reset, !reset && state_ff != ST_ENV2, $stable(env_ff), "envelope moved")
   `SKRC_ASSERT_SAME(a_div_knee, clock, reset, state_ff == ST_DIV, knee_ff != '0, "divide by zero knee")
   `SKRC_ASSERT_SAME(a_rsp_from_done, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == ST_DONE, "stray result")

endmodule

FILE: sim/tb_top.sv
// Self-checking testbench for the soft-knee RMS compressor.
module tb_top;
   import skrc_pkg::*;

   localparam longint CYCLE_LIMIT = 1500000;
   // Index past the last register, expected to do nothing
   localparam logic [2:0] REG_UNUSED = 3'd7;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [23:0] req_sample_zero = '0;
   logic [23:0] req_sample_one = '0;
   logic req_block_end = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [23:0] rsp_result_zero;
   logic [23:0] rsp_result_one;
   logic rsp_result_end;
   logic csr_write_enable = 1'b0;
   logic [2:0] csr_index = '0;
   logic [16:0] csr_data = '0;

   soft_knee_rms_compressor DUT (.*);

   always #2 clock = ~clock;

   typedef struct {
      logic [23:0] zero;
      logic [23:0] one;
      logic        last;
   } frame_out_t;

   frame_out_t gained_q[$];
   int errors = 0;
   longint cycles = 0;
   bit hold_rsp = 1'b0;
   bit run_idle = 1'b1;

   // Predictor copy of the configuration and envelope
   longint thr_cfg, slope_cfg, knee_cfg, att_cfg, rel_cfg, mk_cfg, ch_cfg, env_st;

   function automatic longint round_shift(longint v, int s);
      longint t;
      t = v + (longint'(1) << (s - 1));
      return t >>> s;
   endfunction

   function automatic longint frame_level(longint unsigned ms);
      int p;
      longint unsigned m, mag, d;
      longint frac, l2;
      if (ms == 0) return -32768;
      p = 63;
      while (ms[p] == 1'b0) p--;
      m = (p > 30) ? (ms >> (p - 30)) : (ms << (30 - p));
      frac = 0;
      for (int i = 0; i < 16; i++) begin
         m = (m * m) >> 30;
         if (m >= (64'd1 << 31)) begin
            m = m >> 1;
            frac = frac | (longint'(1) << (15 - i));
         end
      end
      l2 = (longint'(p) - 46) * 65536 + frac;
      if (l2 >= 0) return 0;
      mag = -l2;
      d = (mag * 197283 + (64'd1 << 23)) >> 24;
      if (d > 32768) d = 32768;
      return -longint'(d);
   endfunction

   function automatic longint curve_gain(longint env);
      longint diff, g, t, num;
      longint unsigned den, mag, q;
      diff = env - thr_cfg;
      if (2 * diff < -knee_cfg) g = 0;
      else if (2 * diff < knee_cfg) begin
         t = 2 * diff + knee_cfg;
         num = slope_cfg * t * t;
         den = longint'(8 * knee_cfg) * 65536;
         mag = (num < 0) ? -num : num;
         q = (num < 0) ? (mag + den / 2 - 1) / den : (mag + den / 2) / den;
         g = (num < 0) ? -longint'(q) : longint'(q);
      end else g = round_shift(slope_cfg * diff, 16);
      if (g > 0) g = 0;
      if (g < -32768) g = -32768;
      return g;
   endfunction

   function automatic longint unsigned gain_linear(longint g);
      longint unsigned e, ip, fp, lin;
      e = (longint'(-g) * 2786635 + 32768) >> 16;
      ip = e >> 16;
      fp = e & 16'hFFFF;
      lin = 64'd1 << 30;
      for (int k = 1; k <= 16; k++)
         if (fp[16 - k]) lin = (lin * pow2_neg(4'(k - 1)) + (64'd1 << 29)) >> 30;
      if (ip >= 31) return 0;
      return lin >> ip;
   endfunction

   function automatic frame_out_t compress_frame(logic [23:0] s0, logic [23:0] s1, logic be);
      frame_out_t r;
      longint x[2];
      longint unsigned sum, a, gq;
      longint lvl, env, y;
      longint n;
      n = ch_cfg;
      if (n == 0) n = 1;
      if (n > 2) n = 2;
      x[0] = longint'(signed'(s0));
      x[1] = longint'(signed'(s1));
      sum = 0;
      for (int c = 0; c < n; c++) begin
         a = (x[c] < 0) ? -x[c] : x[c];
         sum += a * a;
      end
      lvl = frame_level(sum / n);
      env = lvl + round_shift(((lvl > env_st) ? att_cfg : rel_cfg) * (env_st - lvl), 16);
      if (env > 32767) env = 32767;
      if (env < -32768) env = -32768;
      env_st = env;
      gq = (gain_linear(curve_gain(env_st)) * mk_cfg + (64'd1 << 14)) >> 15;
      for (int c = 0; c < 2; c++) begin
         y = 0;
         if (c < n) begin
            y = round_shift(x[c] * longint'(gq), 26);
            if (y > 8388607) y = 8388607;
            if (y < -8388608) y = -8388608;
         end
         if (c == 0) r.zero = y[23:0];
         else r.one = y[23:0];
      end
      r.last = be;
      return r;
   endfunction

   // Short gaps mostly, a long one now and then
   function automatic int gap_len();
      int r;
      if (!run_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 150);
   endfunction

   // Write a register once every frame in flight has come out
   task automatic reg_write(logic [2:0] idx, logic [16:0] val);
      req_valid <= 1'b0;
      while (gained_q.size() != 0) @(posedge clock);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         REG_THRESHOLD: thr_cfg = longint'(signed'(val[14:0]));
         REG_SLOPE:     slope_cfg = longint'(signed'(val[16:0]));
         REG_KNEE:      knee_cfg = val[12:0];
         REG_ATTACK:    att_cfg = val[15:0];
         REG_RELEASE:   rel_cfg = val[15:0];
         REG_MAKEUP:    mk_cfg = val[14:0];
         REG_CHANNELS:  ch_cfg = val[1:0];
         default: ;
      endcase
   endtask

   // Wait for the pipeline to drain before touching registers
   task automatic drain();
      req_valid <= 1'b0;
      while (gained_q.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   // Offer one frame; valid stays up after the transfer until the next gap
   task automatic send_frame(logic [23:0] s0, logic [23:0] s1, logic be);
      int g;
      g = gap_len();
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_sample_zero <= s0;
      req_sample_one <= s1;
      req_block_end <= be;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      gained_q.push_back(compress_frame(s0, s1, be));
   endtask

   task automatic rand_frame();
      logic [23:0] s0, s1;
      int k;
      k = $urandom_range(0, 9);
      s0 = $urandom;
      s1 = $urandom;
      // Scale to spread levels across the dB range
      if (k < 6) begin
         s0 = 24'(signed'(s0) >>> $urandom_range(0, 23));
         s1 = 24'(signed'(s1) >>> $urandom_range(0, 23));
      end else if (k == 6) s0 = 24'h000000;
      send_frame(s0, s1, $urandom_range(0, 1));
   endtask

   task automatic test_directed();
      send_frame(24'h7FFFFF, 24'h7FFFFF, 1'b0);
      send_frame(24'h800000, 24'h800000, 1'b1);
      send_frame(24'h000000, 24'h000000, 1'b0);
      send_frame(24'h000001, 24'hFFFFFF, 1'b0);
      send_frame(24'h7FFFFF, 24'h800000, 1'b1);
      send_frame(24'h000000, 24'h000000, 1'b0);
      send_frame(24'h400000, 24'hC00000, 1'b0);
      drain();
      // Hard knee, maximum makeup: saturation
      reg_write(REG_KNEE, 17'd0);
      reg_write(REG_MAKEUP, 17'd32767);
      send_frame(24'h7FFFFF, 24'h800000, 1'b0);
      send_frame(24'h100000, 24'hF00000, 1'b1);
      send_frame(24'h000001, 24'h000000, 1'b0);
      drain();
      // Single channel, channel count zero and too high
      reg_write(REG_CHANNELS, 17'd1);
      send_frame(24'h123456, 24'h654321, 1'b0);
      reg_write(REG_CHANNELS, 17'd0);
      send_frame(24'h7FFFFF, 24'h7FFFFF, 1'b1);
      drain();
      reg_write(REG_CHANNELS, 17'd3);
      send_frame(24'h800000, 24'h7FFFFF, 1'b0);
      drain();
      // Positive slope, deep gain, a low threshold, unknown register
      reg_write(REG_SLOPE, 17'h0FFFF);
      send_frame(24'h7FFFFF, 24'h7FFFFF, 1'b0);
      reg_write(REG_SLOPE, 17'h10000);
      reg_write(REG_THRESHOLD, 17'(-15360));
      reg_write(REG_UNUSED, 17'h1FFFF);
      send_frame(24'h7FFFFF, 24'h800000, 1'b0);
      reg_write(REG_ATTACK, 17'd0);
      reg_write(REG_RELEASE, 17'd65535);
      send_frame(24'h000000, 24'h000000, 1'b1);
      send_frame(24'h7FFFFF, 24'h000000, 1'b0);
      drain();
   endtask

   task automatic random_settings();
      reg_write(REG_THRESHOLD, 17'($urandom_range(0, 15360)) * -17'sd1);
      reg_write(REG_SLOPE, 17'(-$urandom_range(0, 62259)));
      reg_write(REG_KNEE, $urandom_range(0, 3) == 0 ? 17'd0 : 17'($urandom_range(0, 6144)));
      reg_write(REG_ATTACK, 17'($urandom_range(0, 65535)));
      reg_write(REG_RELEASE, 17'($urandom_range(0, 65535)));
      reg_write(REG_MAKEUP, 17'($urandom_range(0, 32767)));
      reg_write(REG_CHANNELS, 17'($urandom_range(0, 3)));
   endtask

   task automatic test_random();
      for (int ph = 0; ph < 19; ph++) begin
         random_settings();
         run_idle = (ph % 4 != 3);
         repeat (100) rand_frame();
         drain();
      end
      run_idle = 1'b1;
   endtask

   task automatic test_backpressure();
      hold_rsp = 1'b1;
      repeat (6) rand_frame();
      hold_rsp = 1'b0;
      drain();
   endtask

   // Drive result stall: random gaps, or a long hold-off on request
   initial begin
      int n;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_stall <= 1'b1;
            n = 0;
            while (n < 2000 && hold_rsp) begin
               @(posedge clock);
               n++;
            end
            rsp_stall <= 1'b0;
         end else begin
            n = gap_len();
            if (n > 0) begin
               rsp_stall <= 1'b1;
               repeat (n) @(posedge clock);
            end
            rsp_stall <= 1'b0;
         end
      end
   end

   // Compare each transfer with the oldest prediction
   always @(posedge clock) begin
      frame_out_t e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (gained_q.size() == 0) begin
            $display("%0t: unexpected result %h %h %b", $time,
                     rsp_result_zero, rsp_result_one, rsp_result_end);
            errors++;
         end else begin
            e = gained_q.pop_front();
            if (rsp_result_zero !== e.zero) begin
               $display("%0t: result_zero expected %h actual %h", $time, e.zero, rsp_result_zero);
               errors++;
            end
            if (rsp_result_one !== e.one) begin
               $display("%0t: result_one expected %h actual %h", $time, e.one, rsp_result_one);
               errors++;
            end
            if (rsp_result_end !== e.last) begin
               $display("%0t: result_end expected %b actual %b", $time, e.last, rsp_result_end);
               errors++;
            end
         end
      end
   end

   // Timeout guard
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      thr_cfg = -4608; slope_cfg = -49152; knee_cfg = 1536; att_cfg = 65400;
      rel_cfg = 65522; mk_cfg = 2048; ch_cfg = 2; env_st = -24576;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_backpressure();
      test_random();
      drain();
      if (errors == 0 && gained_q.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule
